// File: design/idq_pkg.sv
// shared types and constants for the indexed insert deque
`timescale 1ns / 1ps
`default_nettype none
package idq_pkg;

	// default geometry
	localparam int DEPTH_DEF = 16;
	localparam int WIDTH_DEF = 32;

	// fixed payload widths
	localparam int FUNC_W   = 3;
	localparam int VALUE_W  = 32;
	localparam int POS_W    = 5;
	localparam int POPPED_W = 32;
	localparam int STATUS_W = 2;
	localparam int OCC_W    = 5;

	// command codes
	localparam logic [FUNC_W-1:0] FUNC_PUSH_HEAD = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_APPEND    = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_INSERT    = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_POP_HEAD  = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_POP_TAIL  = 3'd4;

	// result status codes
	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK    = 2'd0,
		STATUS_FULL  = 2'd1,
		STATUS_EMPTY = 2'd2
	} status_t;

	// datapath operation
	typedef enum logic [1:0] {
		OP_NONE,
		OP_INSERT,
		OP_POP_HEAD,
		OP_POP_TAIL
	} op_t;

	// controller states
	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic    capture;
		logic    exec;
		op_t     op;
		status_t status;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic              full;
		logic              empty;
	} dp_status_t;

endpackage
`default_nettype wire

// File: design/idq_cmd_if.sv
// command channel: valid/ready with func, value and position
`timescale 1ns / 1ps
`default_nettype none
interface idq_cmd_if;
	import idq_pkg::*;

	logic               valid;
	logic               ready;
	logic [FUNC_W-1:0]  func;
	logic [VALUE_W-1:0] value;
	logic [POS_W-1:0]   position;

	modport source (output valid, func, value, position, input ready);
	modport sink   (input valid, func, value, position, output ready);
endinterface
`default_nettype wire

// File: design/idq_rsp_if.sv
// response channel: valid/ready with popped word, status and occupancy
`timescale 1ns / 1ps
`default_nettype none
interface idq_rsp_if;
	import idq_pkg::*;

	logic                valid;
	logic                ready;
	logic [POPPED_W-1:0] popped_value;
	logic [STATUS_W-1:0] status;
	logic [OCC_W-1:0]    occupancy;

	modport source (output valid, popped_value, status, occupancy, input ready);
	modport sink   (input valid, popped_value, status, occupancy, output ready);
endinterface
`default_nettype wire

// File: design/indexed_insert_deque_top.sv
// top level of the indexed insert deque
//
//  channel  dir  handshake     payload
//  cmd      in   valid/ready   func, value, position
//  rsp      out  valid/ready   popped_value, status, occupancy
//
// each command is first registered, then the cell chain shifts or loads and
// the response register fills; a new command is then taken while the previous
// response may still wait on rsp.
// a stalled rsp holds the next command in the execute cycle until it drains.
// reset clears the count and the handshake state; cell contents are not reset.
`timescale 1ns / 1ps
`default_nettype none
module indexed_insert_deque_top #(
	parameter int DEPTH = idq_pkg::DEPTH_DEF,
	parameter int WIDTH = idq_pkg::WIDTH_DEF
) (
	input wire   clk,
	input wire   arst_n,
	idq_cmd_if.sink   cmd,
	idq_rsp_if.source rsp
);
	import idq_pkg::*;

	ctrl_cmd_t  ctrl;
	dp_status_t dp_stat;

	// controller
	idq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd.valid),
		.cmd_ready (cmd.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.dp_stat   (dp_stat),
		.ctrl      (ctrl)
	);

	// datapath
	idq_dp #(
		.DEPTH (DEPTH),
		.WIDTH (WIDTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (ctrl),
		.dp_stat      (dp_stat),
		.func         (cmd.func),
		.value        (cmd.value),
		.position     (cmd.position),
		.popped_value (rsp.popped_value),
		.status       (rsp.status),
		.occupancy    (rsp.occupancy)
	);

	// one command in flight at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.valid && cmd.ready |=> !cmd.ready)
		else $error("command taken while another is in flight");

	// execution always presents a response
	a_exec_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.exec |=> rsp.valid)
		else $error("executed command left no response");

	// a dropped push pops nothing
	a_full_no_pop: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status == STATUS_FULL |-> rsp.popped_value == '0)
		else $error("dropped push returned a word");

	// an empty pop leaves the store empty
	a_empty_occ: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status == STATUS_EMPTY |-> rsp.occupancy == '0 && rsp.popped_value == '0)
		else $error("empty pop reported words held");

endmodule
`default_nettype wire

// File: design/idq_ctrl.sv
// controller: command sequencing, op decode and response valid
`timescale 1ns / 1ps
`default_nettype none
module idq_ctrl (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      cmd_valid,
	output logic                     cmd_ready,
	output logic                     rsp_valid,
	input  wire                      rsp_ready,
	input  wire idq_pkg::dp_status_t dp_stat,
	output idq_pkg::ctrl_cmd_t       ctrl
);
	import idq_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   rsp_valid_q;
	logic   can_exec;

	// response register is free or being drained this cycle
	assign can_exec = !rsp_valid_q || rsp_ready;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				if (can_exec) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs and op decode
	always_comb begin
		cmd_ready   = 1'b0;
		ctrl        = '0;
		ctrl.op     = OP_NONE;
		ctrl.status = STATUS_OK;
		case (state_q)
			ST_IDLE: begin
				cmd_ready    = 1'b1;
				ctrl.capture = cmd_valid;
			end
			ST_EXEC: begin
				ctrl.exec = can_exec;
			end
			default: begin
				cmd_ready = 1'b0;
			end
		endcase
		case (dp_stat.func) inside
			FUNC_PUSH_HEAD, FUNC_APPEND, FUNC_INSERT: begin
				if (dp_stat.full) ctrl.status = STATUS_FULL;
				else ctrl.op = OP_INSERT;
			end
			FUNC_POP_HEAD: begin
				if (dp_stat.empty) ctrl.status = STATUS_EMPTY;
				else ctrl.op = OP_POP_HEAD;
			end
			FUNC_POP_TAIL: begin
				if (dp_stat.empty) ctrl.status = STATUS_EMPTY;
				else ctrl.op = OP_POP_TAIL;
			end
			default: ctrl.op = OP_NONE;
		endcase
	end

	// state and response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctrl.exec) rsp_valid_q <= 1'b1;
			else if (rsp_ready) rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;

endmodule
`default_nettype wire

// File: design/idq_dp.sv
// datapath: command register, shift chain of cells, count and response register
`timescale 1ns / 1ps
`default_nettype none
module idq_dp #(
	parameter int DEPTH = idq_pkg::DEPTH_DEF,
	parameter int WIDTH = idq_pkg::WIDTH_DEF
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire idq_pkg::ctrl_cmd_t       ctrl,
	output idq_pkg::dp_status_t           dp_stat,
	input  wire [idq_pkg::FUNC_W-1:0]     func,
	input  wire [idq_pkg::VALUE_W-1:0]    value,
	input  wire [idq_pkg::POS_W-1:0]      position,
	output logic [idq_pkg::POPPED_W-1:0]  popped_value,
	output logic [idq_pkg::STATUS_W-1:0]  status,
	output logic [idq_pkg::OCC_W-1:0]     occupancy
);
	import idq_pkg::*;

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int IDX_W = $clog2(DEPTH);

	logic [FUNC_W-1:0]   func_q;
	logic [VALUE_W-1:0]  value_q;
	logic [POS_W-1:0]    pos_q;
	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    count_d;
	logic [WIDTH-1:0]    cell_q [DEPTH];
	logic [WIDTH-1:0]    word;
	logic [63:0]         value_wide;
	logic [31:0]         pos_wide;
	logic [31:0]         count_wide;
	logic [31:0]         occ_wide;
	logic [CNT_W-1:0]    ins_pos;
	logic [CNT_W-1:0]    tail_cnt;
	logic [IDX_W-1:0]    tail_idx;
	logic [WIDTH-1:0]    pop_word;
	logic [63:0]         pop_wide;
	logic [POPPED_W-1:0] popped_q;
	logic [STATUS_W-1:0] status_q;
	logic [OCC_W-1:0]    occ_q;

	// command register
	always_ff @(posedge clk) begin
		if (ctrl.capture) begin
			func_q  <= func;
			value_q <= value;
			pos_q   <= position;
		end
	end

	// status toward the controller
	assign dp_stat.func  = func_q;
	assign dp_stat.full  = (count_q == CNT_W'(DEPTH));
	assign dp_stat.empty = (count_q == '0);

	// stored word keeps the low bits of the command value
	assign value_wide = 64'(value_q);
	assign word       = value_wide[WIDTH-1:0];

	// effective insert position: head, tail or the given place
	assign pos_wide   = 32'(pos_q);
	assign count_wide = 32'(count_q);
	always_comb begin
		if (func_q == FUNC_PUSH_HEAD) ins_pos = '0;
		else if (func_q == FUNC_APPEND || pos_wide >= count_wide) ins_pos = count_q;
		else ins_pos = pos_wide[CNT_W-1:0];
	end

	// cell chain: each cell holds, loads, or takes a neighbor
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		always_ff @(posedge clk) begin
			if (ctrl.exec) begin
				case (ctrl.op)
					OP_INSERT: begin
						if (CNT_W'(i) == ins_pos) cell_q[i] <= word;
						else if (i > 0 && CNT_W'(i) > ins_pos) cell_q[i] <= cell_q[(i > 0) ? i - 1 : 0];
					end
					OP_POP_HEAD: begin
						if (i < DEPTH - 1) cell_q[i] <= cell_q[(i < DEPTH - 1) ? i + 1 : i];
					end
					default: cell_q[i] <= cell_q[i];
				endcase
			end
		end
	end

	// popped word from head or tail
	assign tail_cnt = count_q - CNT_W'(1);
	assign tail_idx = tail_cnt[IDX_W-1:0];
	always_comb begin
		case (ctrl.op)
			OP_POP_HEAD: pop_word = cell_q[0];
			OP_POP_TAIL: pop_word = cell_q[tail_idx];
			default:     pop_word = '0;
		endcase
	end
	assign pop_wide = 64'(pop_word);

	// next count
	always_comb begin
		case (ctrl.op)
			OP_INSERT:                count_d = count_q + CNT_W'(1);
			OP_POP_HEAD, OP_POP_TAIL: count_d = count_q - CNT_W'(1);
			default:                  count_d = count_q;
		endcase
	end
	assign occ_wide = 32'(count_d);

	// count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) count_q <= '0;
		else if (ctrl.exec) count_q <= count_d;
	end

	// response register
	always_ff @(posedge clk) begin
		if (ctrl.exec) begin
			popped_q <= pop_wide[POPPED_W-1:0];
			status_q <= ctrl.status;
			occ_q    <= occ_wide[OCC_W-1:0];
		end
	end

	assign popped_value = popped_q;
	assign status       = status_q;
	assign occupancy    = occ_q;

endmodule
`default_nettype wire

// File: test/idq_response_checker.sv
// response checker for the indexed insert deque: shadow list and field compare
`timescale 1ns / 1ps
`default_nettype none
module idq_response_checker #(
	parameter int DEPTH = idq_pkg::DEPTH_DEF,
	parameter int WIDTH = idq_pkg::WIDTH_DEF
) (
	input wire clk,
	input wire arst_n,
	idq_cmd_if cmd,
	idq_rsp_if rsp,
	output int errors,
	output int outstanding
);
	import idq_pkg::*;

	// one predicted response word
	typedef struct packed {
		logic [POPPED_W-1:0] popped;
		status_t             status;
		logic [OCC_W-1:0]    occ;
	} rsp_word_t;

	// shadow copy of the list contents and fill level
	logic [WIDTH-1:0] shadow_list [DEPTH];
	int               shadow_count;
	int               mismatch_count;
	rsp_word_t        predicted_rsp [$];

	// apply one command to the shadow list and return the response it yields
	function automatic rsp_word_t apply_command(input logic [FUNC_W-1:0] f,
			input logic [VALUE_W-1:0] v, input logic [POS_W-1:0] p);
		rsp_word_t        r;
		logic [WIDTH-1:0] w;
		int               at;
		r.popped = '0;
		r.status = STATUS_OK;
		w = WIDTH'(v);
		case (f)
			FUNC_PUSH_HEAD, FUNC_APPEND, FUNC_INSERT: begin
				if (shadow_count >= DEPTH) begin
					r.status = STATUS_FULL;
				end else begin
					// head push, tail append, or slot the word in at the position
					if (f == FUNC_PUSH_HEAD)
						at = 0;
					else if (f == FUNC_APPEND || int'(p) >= shadow_count)
						at = shadow_count;
					else
						at = int'(p);
					for (int i = shadow_count; i > at; i--)
						shadow_list[i] = shadow_list[i-1];
					shadow_list[at] = w;
					shadow_count++;
				end
			end
			FUNC_POP_HEAD: begin
				if (shadow_count == 0) begin
					r.status = STATUS_EMPTY;
				end else begin
					r.popped = POPPED_W'(shadow_list[0]);
					for (int i = 1; i < shadow_count; i++)
						shadow_list[i-1] = shadow_list[i];
					shadow_count--;
				end
			end
			FUNC_POP_TAIL: begin
				if (shadow_count == 0) begin
					r.status = STATUS_EMPTY;
				end else begin
					shadow_count--;
					r.popped = POPPED_W'(shadow_list[shadow_count]);
				end
			end
			// unused codes leave the list alone
			default: ;
		endcase
		r.occ = OCC_W'(shadow_count);
		return r;
	endfunction

	// compare responses first, then predict for the command taken at this edge
	always @(posedge clk or negedge arst_n) begin
		rsp_word_t want;
		if (!arst_n) begin
			shadow_count = 0;
			mismatch_count = 0;
			predicted_rsp.delete();
			errors <= 0;
			outstanding <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (predicted_rsp.size() == 0) begin
					$display("%0t: unexpected response word: popped %h status %0d occupancy %0d",
						$time, rsp.popped_value, rsp.status, rsp.occupancy);
					mismatch_count++;
				end else begin
					want = predicted_rsp.pop_front();
					if (rsp.popped_value !== want.popped) begin
						$display("%0t: popped_value mismatch: expected %h actual %h",
							$time, want.popped, rsp.popped_value);
						mismatch_count++;
					end
					if (rsp.status !== want.status) begin
						$display("%0t: status mismatch: expected %0d actual %0d",
							$time, want.status, rsp.status);
						mismatch_count++;
					end
					if (rsp.occupancy !== want.occ) begin
						$display("%0t: occupancy mismatch: expected %0d actual %0d",
							$time, want.occ, rsp.occupancy);
						mismatch_count++;
					end
				end
			end
			if (cmd.valid && cmd.ready)
				predicted_rsp.push_back(apply_command(cmd.func, cmd.value, cmd.position));
			errors <= mismatch_count;
			outstanding <= predicted_rsp.size();
		end
	end

endmodule
`default_nettype wire

// File: test/tb_indexed_insert_deque_top.sv
// testbench top for the indexed insert deque: stimulus, stalls and verdict
`timescale 1ns / 1ps
`default_nettype none
module tb_indexed_insert_deque_top;
	import idq_pkg::*;

	localparam int CLK_PERIOD   = 20;
	localparam int ITEM_TARGET  = 900;
	localparam int CYCLE_LIMIT  = 500000;
	localparam int DRAIN_CYCLES = 10;

	// receiver stall patterns
	typedef enum logic [1:0] {
		RX_OPEN,
		RX_LIGHT,
		RX_HEAVY,
		RX_BLOCK
	} rx_mode_t;

	// command mix of a random phase
	typedef enum logic [1:0] {
		MIX_FILL,
		MIX_DRAIN,
		MIX_EVEN
	} mix_t;

	logic     clk = 1'b0;
	logic     arst_n;
	logic     rx_ready = 1'b0;
	rx_mode_t rx_mode;
	int       rx_left;
	int       errors;
	int       outstanding;
	int       cycles = 0;
	int       burst_left = 0;

	idq_cmd_if cmd ();
	idq_rsp_if rsp ();

	indexed_insert_deque_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.rsp    (rsp)
	);

	idq_response_checker rsp_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.rsp         (rsp),
		.errors      (errors),
		.outstanding (outstanding)
	);

	// clock
	always #(CLK_PERIOD / 2) clk = ~clk;

	// receiver stalls: a new random pattern whenever the current one runs out
	assign rsp.ready = rx_ready;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_ready <= 1'b0;
			rx_mode <= RX_OPEN;
			rx_left <= 0;
		end else if (rx_left == 0) begin
			rx_mode <= rx_mode_t'($urandom_range(0, 3));
			rx_left <= $urandom_range(4, 40);
			rx_ready <= 1'b1;
		end else begin
			rx_left <= rx_left - 1;
			case (rx_mode)
				RX_OPEN:  rx_ready <= 1'b1;
				RX_LIGHT: rx_ready <= ($urandom_range(0, 3) != 0);
				RX_HEAVY: rx_ready <= ($urandom_range(0, 3) == 0);
				default:  rx_ready <= 1'b0;
			endcase
		end
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// send one command word, with a random gap between bursts
	task automatic send_word(input logic [FUNC_W-1:0] f, input logic [VALUE_W-1:0] v,
			input logic [POS_W-1:0] p);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(1, 8);
			cmd.valid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = $urandom_range(1, 32);
		end
		burst_left--;
		cmd.valid <= 1'b1;
		cmd.func <= f;
		cmd.value <= v;
		cmd.position <= p;
		do @(posedge clk); while (!cmd.ready);
	endtask

	// hold the sender until every predicted response has come back
	task automatic hold_until_drained();
		cmd.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		burst_left = $urandom_range(1, 32);
	endtask

	// directed: empty pops, unused codes, every insert flavor, value extremes
	task automatic run_directed();
		send_word(FUNC_POP_HEAD, '0, '0);
		send_word(FUNC_POP_TAIL, '0, '0);
		for (int f = FUNC_POP_TAIL + 1; f < (1 << FUNC_W); f++)
			send_word(FUNC_W'(f), '1, '1);
		send_word(FUNC_PUSH_HEAD, 32'hFFFF_FFFF, '0);
		send_word(FUNC_APPEND, 32'h0000_0000, '1);
		send_word(FUNC_INSERT, 32'hA5A5_A5A5, 5'd0);
		send_word(FUNC_INSERT, 32'h5A5A_5A5A, 5'd1);
		send_word(FUNC_INSERT, 32'h0123_4567, 5'd31);
		send_word(FUNC_INSERT, 32'h89AB_CDEF, 5'd16);
		send_word(FUNC_INSERT, 32'hDEAD_BEEF, 5'd5);
		send_word(FUNC_INSERT, 32'h8000_0001, 5'd2);
		send_word(FUNC_POP_HEAD, '0, '0);
		send_word(FUNC_POP_TAIL, '0, '0);
		send_word(FUNC_POP_HEAD, '0, '0);
		send_word(FUNC_POP_TAIL, '0, '0);
		hold_until_drained();
	endtask

	// random phases biased to fill, drain or hover, so full and empty both recur
	task automatic run_random();
		mix_t               mix;
		int                 phase_len;
		int                 phase_no;
		int                 sent;
		int                 add_pct;
		int                 pick;
		logic [FUNC_W-1:0]  f;
		logic [VALUE_W-1:0] v;
		logic [POS_W-1:0]   p;
		sent = 0;
		phase_no = 0;
		while (sent < ITEM_TARGET) begin
			mix = mix_t'($urandom_range(0, 2));
			phase_len = $urandom_range(10, 60);
			add_pct = (mix == MIX_FILL) ? 80 : (mix == MIX_DRAIN) ? 20 : 50;
			repeat (phase_len) begin
				if ($urandom_range(0, 99) < 3) begin
					f = FUNC_W'($urandom_range(FUNC_POP_TAIL + 1, (1 << FUNC_W) - 1));
				end else if ($urandom_range(0, 99) < add_pct) begin
					pick = $urandom_range(0, 3);
					f = (pick == 0) ? FUNC_PUSH_HEAD : (pick == 1) ? FUNC_APPEND : FUNC_INSERT;
				end else begin
					f = $urandom_range(0, 1) ? FUNC_POP_HEAD : FUNC_POP_TAIL;
				end
				pick = $urandom_range(0, 99);
				v = (pick < 5) ? '1 : (pick < 10) ? '0 : VALUE_W'($urandom);
				pick = $urandom_range(0, 99);
				if (pick < 10)
					p = POS_W'($urandom_range(0, (1 << POS_W) - 1));
				else if (pick < 25)
					p = POS_W'($urandom_range(0, 2));
				else
					p = POS_W'($urandom_range(0, DEPTH_DEF));
				send_word(f, v, p);
				sent++;
			end
			phase_no++;
			if (phase_no % 4 == 1)
				hold_until_drained();
		end
	endtask

	// reset, stimulus, drain and verdict
	initial begin
		cmd.valid <= 1'b0;
		cmd.func <= FUNC_PUSH_HEAD;
		cmd.value <= '0;
		cmd.position <= '0;
		arst_n <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		run_random();
		hold_until_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
`default_nettype wire
